### hdl/ctg_pkg.sv
// Shared types and constants of the color to gray converter.
`default_nettype none

package ctg_pkg;

    localparam int unsigned WEIGHT_FRAC_BITS_DEF = 12;

    localparam int unsigned COMP_W   = 8;
    localparam int unsigned WEIGHT_W = 16;
    localparam int unsigned PROD_W   = COMP_W + 1 + WEIGHT_W;
    localparam int unsigned SUM_W    = PROD_W + 2;
    localparam int unsigned CFG_AW   = 3;
    localparam int unsigned CFG_DW   = WEIGHT_W;
    localparam int unsigned IN_DW    = 4 * COMP_W;
    localparam int unsigned OUT_DW   = COMP_W;

    localparam logic signed [WEIGHT_W-1:0] W_RESET_FIRST  = 16'sd870;
    localparam logic signed [WEIGHT_W-1:0] W_RESET_SECOND = 16'sd2930;
    localparam logic signed [WEIGHT_W-1:0] W_RESET_THIRD  = 16'sd295;

    localparam logic [CFG_AW-1:0] CFG_MODE           = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_WEIGHT_FIRST   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_WEIGHT_SECOND  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_WEIGHT_THIRD   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_CHANNEL_SELECT = 3'd4;

    typedef enum logic [1:0] {
        MODE_LUMINOSITY = 2'd0,
        MODE_AVERAGE    = 2'd1,
        MODE_LIGHTNESS  = 2'd2,
        MODE_SINGLE     = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                       mode;
        logic signed [WEIGHT_W-1:0]  weight_first;
        logic signed [WEIGHT_W-1:0]  weight_second;
        logic signed [WEIGHT_W-1:0]  weight_third;
        logic [1:0]                  channel_select;
    } t_cfg;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_pipe_en;

endpackage

`default_nettype wire

### hdl/ctg_cfg_regs.sv
// Configuration register file of the color to gray converter.
`default_nettype none

module ctg_cfg_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [ctg_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [ctg_pkg::CFG_DW-1:0]  i_cfg_data,
    output ctg_pkg::t_cfg                    o_cfg
);
    import ctg_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MODE:           n_cfg.mode           = t_mode'(i_cfg_data[1:0]);
                CFG_WEIGHT_FIRST:   n_cfg.weight_first   = $signed(i_cfg_data);
                CFG_WEIGHT_SECOND:  n_cfg.weight_second  = $signed(i_cfg_data);
                CFG_WEIGHT_THIRD:   n_cfg.weight_third   = $signed(i_cfg_data);
                CFG_CHANNEL_SELECT: n_cfg.channel_select = i_cfg_data[1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= MODE_LUMINOSITY;
            r_cfg.weight_first   <= W_RESET_FIRST;
            r_cfg.weight_second  <= W_RESET_SECOND;
            r_cfg.weight_third   <= W_RESET_THIRD;
            r_cfg.channel_select <= 2'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### hdl/ctg_datapath.sv
// Three-stage payload pipeline: products and extremes, sum and lightness, rounding and output select.
`default_nettype none

module ctg_datapath #(
    parameter int unsigned WEIGHT_FRAC_BITS = ctg_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire ctg_pkg::t_cfg               i_cfg,
    input  wire ctg_pkg::t_pipe_en           i_en,
    input  wire logic [ctg_pkg::IN_DW-1:0]   i_pixel,
    output logic      [ctg_pkg::OUT_DW-1:0]  o_gray
);
    import ctg_pkg::*;

    localparam logic signed [WEIGHT_W-1:0] AVG_WEIGHT =
        WEIGHT_W'(((3333 << WEIGHT_FRAC_BITS) + 5000) / 10000);
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1 << (WEIGHT_FRAC_BITS - 1));

    logic [COMP_W-1:0] c0, c1, c2, c3;
    logic signed [WEIGHT_W-1:0] w0, w1, w2;
    logic [COMP_W-1:0] lo01, hi01, lo, hi;
    logic [COMP_W-1:0] chan;

    // Stage 1 registers.
    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2;
    logic [COMP_W-1:0]        r_lo1, r_hi1, r_chan1;
    t_mode                    r_mode1;

    // Stage 2 registers.
    logic signed [SUM_W-1:0]  r_sum;
    logic [COMP_W-1:0]        r_light, r_chan2;
    t_mode                    r_mode2;

    // Stage 3 register.
    logic [COMP_W-1:0]        r_gray;

    logic [COMP_W:0]          light_sum;
    logic signed [SUM_W-1:0]  rounded;
    logic [COMP_W-1:0]        weighted;
    logic [COMP_W-1:0]        n_gray;

    assign c0 = i_pixel[0*COMP_W +: COMP_W];
    assign c1 = i_pixel[1*COMP_W +: COMP_W];
    assign c2 = i_pixel[2*COMP_W +: COMP_W];
    assign c3 = i_pixel[3*COMP_W +: COMP_W];

    assign w0 = (i_cfg.mode == MODE_AVERAGE) ? AVG_WEIGHT : i_cfg.weight_first;
    assign w1 = (i_cfg.mode == MODE_AVERAGE) ? AVG_WEIGHT : i_cfg.weight_second;
    assign w2 = (i_cfg.mode == MODE_AVERAGE) ? AVG_WEIGHT : i_cfg.weight_third;

    assign lo01 = (c1 < c0) ? c1 : c0;
    assign hi01 = (c1 > c0) ? c1 : c0;
    assign lo   = (c2 < lo01) ? c2 : lo01;
    assign hi   = (c2 > hi01) ? c2 : hi01;

    always_comb begin
        case (i_cfg.channel_select)
            2'd0:    chan = c0;
            2'd1:    chan = c1;
            2'd2:    chan = c2;
            default: chan = c3;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en1) begin
            r_p0    <= $signed({1'b0, c0}) * w0;
            r_p1    <= $signed({1'b0, c1}) * w1;
            r_p2    <= $signed({1'b0, c2}) * w2;
            r_lo1   <= lo;
            r_hi1   <= hi;
            r_chan1 <= chan;
            r_mode1 <= i_cfg.mode;
        end
    end

    assign light_sum = {1'b0, r_lo1} + {1'b0, r_hi1} + (COMP_W + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_sum   <= SUM_W'(r_p0) + SUM_W'(r_p1) + SUM_W'(r_p2);
            r_light <= light_sum[COMP_W:1];
            r_chan2 <= r_chan1;
            r_mode2 <= r_mode1;
        end
    end

    // Rounding half away from zero: a negative sum gives up one unit before the shift.
    assign rounded  = r_sum + HALF - $signed({{(SUM_W-1){1'b0}}, r_sum[SUM_W-1]});
    assign weighted = rounded[WEIGHT_FRAC_BITS +: COMP_W];

    always_comb begin
        unique case (r_mode2)
            MODE_LUMINOSITY, MODE_AVERAGE: n_gray = weighted;
            MODE_LIGHTNESS:                n_gray = r_light;
            default:                       n_gray = r_chan2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en3) begin
            r_gray <= n_gray;
        end
    end

    assign o_gray = r_gray;

endmodule

`default_nettype wire

### hdl/color_to_gray_converter_core.sv
// Path: an accepted input beat passes the stage-one, stage-two and stage-three registers to its output beat.
// Throughput: one pixel per cycle while the output is not stalled; the three pipeline registers each hold one beat.
// A stalled output holds the output beat and every full stage behind it; empty stages still fill.
// Reset: synchronous, active low; clears valid bits and loads the default weights.
// Top level of the color to gray converter.
`default_nettype none

module color_to_gray_converter_core #(
    parameter int unsigned WEIGHT_FRAC_BITS = ctg_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [ctg_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [ctg_pkg::CFG_DW-1:0]  i_cfg_data,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0: comp_zero, comp_one, comp_two, comp_three.
    input  wire logic [ctg_pkg::IN_DW-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // Fields from bit 0: gray.
    output logic      [ctg_pkg::OUT_DW-1:0]  m_axis_tdata
);
    import ctg_pkg::*;

    t_cfg     cfg;
    t_pipe_en pipe_en;
    logic     r_v1, r_v2, r_v3;
    logic     ready1, ready2, ready3;

    ctg_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign ready3 = !r_v3 || m_axis_tready;
    assign ready2 = !r_v2 || ready3;
    assign ready1 = !r_v1 || ready2;

    assign pipe_en.en1 = ready1;
    assign pipe_en.en2 = ready2;
    assign pipe_en.en3 = ready3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ready1) r_v1 <= s_axis_tvalid;
            if (ready2) r_v2 <= r_v1;
            if (ready3) r_v3 <= r_v2;
        end
    end

    ctg_datapath #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_cfg   (cfg),
        .i_en    (pipe_en),
        .i_pixel (s_axis_tdata),
        .o_gray  (m_axis_tdata)
    );

    assign s_axis_tready = ready1;
    assign m_axis_tvalid = r_v3;

`ifndef SYNTHESIS
    a_full_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while the pipeline is full and stalled");

    a_accept_fills_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_v1)
        else $error("accepted beat lost at stage one");

    a_stage2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !ready3) |=> r_v2)
        else $error("stage two beat dropped during a stall");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && ready3) |=> r_v3)
        else $error("stage two beat did not reach the output register");
`endif

endmodule

`default_nettype wire
